// File: hw/rtl/ppc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_pkg: shared types and constants for the protected port classifier
// Holds the operation codes, the classified transaction record and the
// layout of the combined port bitmap memory.
// ----------------------------------------------------------------------------
package ppc_pkg;

    localparam int PORT_W = 16;
    localparam int BIT_W  = 4;                  // port bits that select a bit in a row
    localparam int ROW_W  = PORT_W - BIT_W;     // port bits that select a row
    localparam int ROWS   = 1 << ROW_W;
    localparam int HALF_W = 1 << BIT_W;         // one map's bits in a row
    localparam int WORD_W = 2 * HALF_W;         // single map low half, except map high half

    typedef enum logic [1:0] {
        OP_SINGLE = 2'd0,
        OP_EXCEPT = 2'd1,
        OP_RANGE  = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [PORT_W-1:0] lo;      // port, or lower range end
        logic [PORT_W-1:0] hi;      // upper range end
    } item_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_MAP,
        B_SCAN,
        B_DONE
    } bstate_t;

endpackage

// File: hw/rtl/protected_port_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// protected_port_classifier: protected port classifier top level
// Flow: a single, except or query transaction is dispatched with its bitmap
//   row read, then written or answered once the result register is free.
//   The back end takes no new transaction until the last one is done; a range
//   insert takes a dispatch step, merge passes over the slots (one pass more
//   than the passes that merge something, unless a covering slot ends it) and
//   a result step. Reset: after rst_n the bitmap memory is cleared row by row
//   with in_stall high; the range table and exception flag clear at once.
// ----------------------------------------------------------------------------
module protected_port_classifier #(
    parameter int RANGE_SLOTS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  mode,
    input  logic [ppc_pkg::PORT_W-1:0]  port_a,
    input  logic [ppc_pkg::PORT_W-1:0]  port_b,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        is_protected,
    output logic                        status
);
    import ppc_pkg::*;

    logic   clearing;
    logic   q_valid;
    logic   q_pop;
    item_t  q_item;

    // Front: accept each transaction, order range ends, queue it
    ppc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .port_a   (port_a),
        .port_b   (port_b),
        .hold     (clearing),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Back: bitmap read-modify-write, range merge sequencer, result register
    ppc_back #(.RANGE_SLOTS(RANGE_SLOTS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .clearing     (clearing),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_protected (is_protected),
        .status       (status)
    );

endmodule

// File: hw/rtl/ppc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ppc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/ppc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_front: accept and classify
// Decodes each incoming transaction, puts range ends in order and holds
// it in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ppc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  mode,
    input  logic [ppc_pkg::PORT_W-1:0]  port_a,
    input  logic [ppc_pkg::PORT_W-1:0]  port_b,
    input  logic                        hold,
    output logic                        q_valid,
    output ppc_pkg::item_t              q_item,
    input  logic                        q_pop
);
    import ppc_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    item_t       cls;
    logic        push;

    // Classify: order range ends, carry the port in lo otherwise
    always_comb
    begin
        cls.op = op_t'(mode);
        cls.lo = port_a;
        cls.hi = port_b;
        if (op_t'(mode) == OP_RANGE && port_b < port_a)
        begin
            cls.lo = port_b;
            cls.hi = port_a;
        end
    end

    assign in_stall = hold || (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// File: hw/rtl/ppc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_back: execute
// Clears the bitmap memory after reset, runs bitmap updates and queries
// by read-modify-write, and merges ranges into the slot table one slot
// per cycle. Drives the result register.
// ----------------------------------------------------------------------------
module ppc_back #(
    parameter int RANGE_SLOTS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    output logic                  clearing,
    input  logic                  q_valid,
    input  ppc_pkg::item_t        q_item,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  is_protected,
    output logic                  status
);
    import ppc_pkg::*;

    localparam int SLOT_W = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;

    bstate_t            state_reg, state_next;
    item_t              cur_reg, cur_next;
    logic [ROW_W-1:0]   clr_reg, clr_next;
    logic               exc_any_reg, exc_any_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic               changed_reg, changed_next;
    logic               free_found_reg, free_found_next;
    logic [SLOT_W-1:0]  free_idx_reg, free_idx_next;
    logic               dstat_reg, dstat_next;
    logic [PORT_W-1:0]  lo_reg, lo_next, hi_reg, hi_next;

    logic [PORT_W-1:0]       rlow_reg  [RANGE_SLOTS];
    logic [PORT_W-1:0]       rhigh_reg [RANGE_SLOTS];
    logic [RANGE_SLOTS-1:0]  rvalid_reg, rvalid_next;
    logic [RANGE_SLOTS-1:0]  hit_reg, hit_next;
    logic                    rwrite;
    logic [SLOT_W-1:0]       rwrite_idx;

    logic               out_valid_reg, out_valid_next;
    logic               prot_reg, prot_next;
    logic               status_reg, status_next;
    logic               out_free;

    logic               we;
    logic [ROW_W-1:0]   waddr, raddr;
    logic [WORD_W-1:0]  wdata, rdata;
    logic [HALF_W-1:0]  mask, exc_half;

    logic [PORT_W-1:0]  slo, shi;
    logic               overlap, covered, last;

    ppc_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_map (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign clearing = (state_reg == B_CLEAR);
    assign raddr    = (state_reg == B_IDLE) ? q_item.lo[PORT_W-1:BIT_W]
                                            : cur_reg.lo[PORT_W-1:BIT_W];
    assign mask     = HALF_W'(1) << cur_reg.lo[BIT_W-1:0];
    assign exc_half = rdata[WORD_W-1:HALF_W];

    assign slo      = rlow_reg[idx_reg];
    assign shi      = rhigh_reg[idx_reg];
    assign overlap  = rvalid_reg[idx_reg] && !(shi < lo_reg || hi_reg < slo);
    assign covered  = slo <= lo_reg && shi >= hi_reg;
    assign last     = (idx_reg == SLOT_W'(RANGE_SLOTS - 1));

    // Per-slot hit for a query, taken at dispatch
    always_comb
    begin
        for (int i = 0; i < RANGE_SLOTS; i++)
        begin
            hit_next[i] = rvalid_reg[i] && rlow_reg[i] <= q_item.lo
                          && q_item.lo <= rhigh_reg[i];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        clr_next        = clr_reg;
        exc_any_next    = exc_any_reg;
        idx_next        = idx_reg;
        changed_next    = changed_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        dstat_next      = dstat_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        rvalid_next     = rvalid_reg;
        rwrite          = 1'b0;
        rwrite_idx      = free_idx_reg;
        out_valid_next  = out_valid_reg && out_stall;
        prot_next       = prot_reg;
        status_next     = status_reg;
        q_pop           = 1'b0;
        we              = 1'b0;
        waddr           = cur_reg.lo[PORT_W-1:BIT_W];
        wdata           = rdata;

        unique case (state_reg)
            B_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + ROW_W'(1);
                if (&clr_reg)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    if (q_item.op == OP_RANGE)
                    begin
                        lo_next         = q_item.lo;
                        hi_next         = q_item.hi;
                        idx_next        = '0;
                        changed_next    = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = B_SCAN;
                    end
                    else
                    begin
                        state_next = B_MAP;
                    end
                end
            end
            B_MAP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = 1'b0;
                    prot_next      = 1'b0;
                    state_next     = B_IDLE;
                    case (cur_reg.op)
                        OP_SINGLE:
                        begin
                            we    = 1'b1;
                            wdata = rdata | {{HALF_W{1'b0}}, mask};
                        end
                        OP_EXCEPT:
                        begin
                            we           = 1'b1;
                            wdata        = rdata | {mask, {HALF_W{1'b0}}};
                            exc_any_next = 1'b1;
                        end
                        default:
                        begin
                            prot_next = |(rdata[HALF_W-1:0] & mask)
                                        || (exc_any_reg ? !(|(exc_half & mask))
                                                        : |hit_reg);
                        end
                    endcase
                end
            end
            B_SCAN:
            begin
                if (overlap && covered)
                begin
                    dstat_next = 1'b0;
                    state_next = B_DONE;
                end
                else
                begin
                    if (overlap)
                    begin
                        if (slo < lo_reg) lo_next = slo;
                        if (shi > hi_reg) hi_next = shi;
                        rvalid_next[idx_reg] = 1'b0;
                        changed_next         = 1'b1;
                    end
                    else if (!rvalid_reg[idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    idx_next = idx_reg + SLOT_W'(1);
                    if (last)
                    begin
                        idx_next = '0;
                        if (changed_next)
                        begin
                            changed_next    = 1'b0;
                            free_found_next = 1'b0;
                        end
                        else
                        begin
                            state_next = B_DONE;
                            dstat_next = !free_found_next;
                            if (free_found_next)
                            begin
                                rwrite                  = 1'b1;
                                rwrite_idx              = free_idx_next;
                                rvalid_next[free_idx_next] = 1'b1;
                            end
                        end
                    end
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    prot_next      = 1'b0;
                    status_next    = dstat_reg;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_CLEAR;
            clr_reg        <= '0;
            exc_any_reg    <= 1'b0;
            rvalid_reg     <= '0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            changed_reg    <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            exc_any_reg    <= exc_any_next;
            rvalid_reg     <= rvalid_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
            changed_reg    <= changed_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        free_idx_reg <= free_idx_next;
        dstat_reg    <= dstat_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        prot_reg     <= prot_next;
        status_reg   <= status_next;
        // hold the hits of the dispatched query while its result waits
        if (state_reg == B_IDLE)
        begin
            hit_reg <= hit_next;
        end
        if (rwrite)
        begin
            rlow_reg[rwrite_idx]  <= lo_next;
            rhigh_reg[rwrite_idx] <= hi_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign is_protected = prot_reg;
    assign status       = status_reg;

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_CLEAR |-> !out_valid_reg)
        else $error("result during clearing pass");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == B_CLEAR || state_reg == B_MAP))
        else $error("bitmap write outside clear or update");

    a_excl_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(prot_reg && status_reg))
        else $error("protected and dropped in one result");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == B_MAP || state_reg == B_SCAN))
        else $error("pop did not start work");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the protected port classifier
// Feeds add, range and query transactions through a bursty driver, stalls
// the result channel on its own pattern, and checks every result against a
// behavioral copy of the port bitmaps and the merged range table.
// ----------------------------------------------------------------------------
module testbench;
    import ppc_pkg::*;

    localparam int SLOTS     = 16;
    localparam int RAND_N    = 1900;
    localparam int CYCLE_CAP = 4000000;

    typedef struct packed {
        logic [1:0]        mode;
        logic [PORT_W-1:0] pa;
        logic [PORT_W-1:0] pb;
    } txn_t;

    typedef struct packed {
        logic prot;
        logic stat;
    } answer_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        mode;
    logic [PORT_W-1:0] port_a;
    logic [PORT_W-1:0] port_b;
    logic              out_valid;
    logic              out_stall;
    logic              is_protected;
    logic              status;

    protected_port_classifier #(.RANGE_SLOTS(SLOTS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .port_a(port_a), .port_b(port_b),
        .out_valid(out_valid), .out_stall(out_stall),
        .is_protected(is_protected), .status(status)
    );

    // Behavioral copy of the classifier state
    bit               single_map [65536];
    bit               except_map [65536];
    bit               except_seen;
    bit [PORT_W-1:0]  span_lo [SLOTS];
    bit [PORT_W-1:0]  span_hi [SLOTS];
    bit               span_used [SLOTS];

    txn_t    pending_txns[$];
    answer_t expected_answers[$];
    int      mismatches;
    int      cycles;
    int      burst_left;
    int      gap_left;
    int      stall_phase;
    int      stall_len;

    always
    begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    // Merge a range into the table; return 1 when the table has no room.
    function automatic bit merge_range(bit [PORT_W-1:0] a, bit [PORT_W-1:0] b);
        bit [PORT_W-1:0] lo;
        bit [PORT_W-1:0] hi;
        bit              grew;
        lo   = (a < b) ? a : b;
        hi   = (a < b) ? b : a;
        grew = 1'b1;
        while (grew)
        begin
            grew = 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!span_used[i] || span_hi[i] < lo || hi < span_lo[i])
                    continue;
                // already covered: leave the table alone
                if (span_lo[i] <= lo && span_hi[i] >= hi)
                    return 1'b0;
                if (span_lo[i] < lo) lo = span_lo[i];
                if (span_hi[i] > hi) hi = span_hi[i];
                span_used[i] = 1'b0;
                grew         = 1'b1;
            end
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!span_used[i])
            begin
                span_used[i] = 1'b1;
                span_lo[i]   = lo;
                span_hi[i]   = hi;
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic answer_t classify(txn_t t);
        answer_t r;
        r = '0;
        case (op_t'(t.mode))
            OP_SINGLE: single_map[t.pa] = 1'b1;
            OP_EXCEPT:
            begin
                except_map[t.pa] = 1'b1;
                except_seen      = 1'b1;
            end
            OP_RANGE:  r.stat = merge_range(t.pa, t.pb);
            OP_QUERY:
            begin
                if (single_map[t.pa])
                    r.prot = 1'b1;
                else if (except_seen)
                    r.prot = !except_map[t.pa];
                else
                    for (int i = 0; i < SLOTS; i++)
                        if (span_used[i] && span_lo[i] <= t.pa && t.pa <= span_hi[i])
                            r.prot = 1'b1;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic push_txn(op_t op, int a, int b);
        txn_t t;
        t.mode = op;
        t.pa   = a[PORT_W-1:0];
        t.pb   = b[PORT_W-1:0];
        pending_txns.push_back(t);
    endtask

    // Port picked at random or near one of three hot spots so adds and queries collide
    function automatic int pick_port();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 65535);
            1:       return $urandom_range(0, 40);
            2:       return $urandom_range(65500, 65535);
            default: return $urandom_range(1000, 1300);
        endcase
    endfunction

    // Driver: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            mode       <= '0;
            port_a     <= '0;
            port_b     <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            // previous transaction taken (or none): advance to the next one
            if (in_valid)
                expected_answers.push_back(classify({mode, port_a, port_b}));
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_txns.size() > 0)
            begin
                txn_t t;
                t = pending_txns.pop_front();
                in_valid <= 1'b1;
                mode     <= t.mode;
                port_a   <= t.pa;
                port_b   <= t.pb;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result-side stall pattern: runs of open cycles and runs of stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_phase <= 0;
            stall_len   <= 20;
        end
        else if (stall_phase >= stall_len)
        begin
            stall_phase <= 0;
            out_stall   <= !out_stall;
            stall_len   <= out_stall ? $urandom_range(1, 40) : $urandom_range(1, 5);
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            // inside an open run, now and then raise a stall that holds to the end of the run
            if (!out_stall && $urandom_range(0, 7) == 0)
                out_stall <= 1'b1;
            else if (stall_len > 5 && out_stall && stall_phase == 0)
                out_stall <= 1'b0;
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_answers.size() == 0)
                report_mismatch("unexpected result, is_protected", is_protected, -1);
            else
            begin
                answer_t w;
                w = expected_answers.pop_front();
                if (is_protected !== w.prot)
                    report_mismatch("is_protected", is_protected, w.prot);
                if (status !== w.stat)
                    report_mismatch("status", status, w.stat);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        int kind;
        int base;
        cycles      = 0;
        mismatches  = 0;
        except_seen = 0;
        for (int i = 0; i < SLOTS; i++) span_used[i] = 0;
        rst_n     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: range rules while no exception exists
        push_txn(OP_QUERY, 0, 0);
        push_txn(OP_QUERY, 65535, 0);
        push_txn(OP_RANGE, 200, 100);       // reversed ends
        push_txn(OP_QUERY, 100, 0);
        push_txn(OP_QUERY, 200, 0);
        push_txn(OP_QUERY, 201, 0);
        push_txn(OP_RANGE, 201, 300);       // adjacent, stays separate
        push_txn(OP_RANGE, 120, 150);       // already covered
        push_txn(OP_RANGE, 150, 250);       // overlap chains both
        push_txn(OP_RANGE, 0, 0);
        push_txn(OP_RANGE, 65535, 65535);
        push_txn(OP_QUERY, 65535, 0);
        push_txn(OP_SINGLE, 65535, 0);
        push_txn(OP_SINGLE, 65535, 0);      // repeated add
        push_txn(OP_SINGLE, 0, 0);
        push_txn(OP_QUERY, 99, 0);
        // fill the table with isolated ranges, then overflow it
        for (int i = 0; i < 16; i++)
            push_txn(OP_RANGE, 1000 + 10 * i, 1002 + 10 * i);
        push_txn(OP_RANGE, 5000, 5001);
        push_txn(OP_QUERY, 5000, 0);
        push_txn(OP_EXCEPT, 300, 0);        // ranges now ignored by queries
        push_txn(OP_QUERY, 300, 0);
        push_txn(OP_QUERY, 150, 0);
        push_txn(OP_QUERY, 0, 0);

        // Random: a fresh state only exists after reset, so the range table
        // keeps churning via merges, and exceptions appear late in the run.
        for (int n = 0; n < RAND_N; n++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
                push_txn(OP_QUERY, pick_port(), $urandom_range(0, 65535));
            else if (kind < 55)
                push_txn(OP_SINGLE, pick_port(), $urandom_range(0, 65535));
            else if (kind < 58 && n > RAND_N / 2)
                push_txn(OP_EXCEPT, pick_port(), $urandom_range(0, 65535));
            else if (kind < 80)
            begin
                base = pick_port();
                push_txn(OP_RANGE, base, base + $urandom_range(0, 20));
            end
            else
                push_txn(OP_RANGE, pick_port(), pick_port());
        end

        wait (pending_txns.size() == 0 && !in_valid);
        wait (expected_answers.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/ppc_pkg.sv
hw/rtl/ppc_ram.sv
hw/rtl/ppc_front.sv
hw/rtl/ppc_back.sv
hw/rtl/protected_port_classifier.sv
test/testbench.sv
